### src/bpq_pkg.sv
`timescale 1ns / 1ps

package bpq_pkg;

  // Default number of entries the queue can hold.
  localparam int unsigned BpqCapacity = 8;

  // Field widths of one item.
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned StatW  = 2;

  // Command codes carried in the input tuser.
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRemove = 1'b1;

  // Status codes carried in the output tuser.
  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatFull  = 2'd1;
  localparam logic [StatW-1:0] StatEmpty = 2'd2;

  // One stored entry.
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } bpq_entry_t;

  // Shift commands broadcast to every cell in the row.
  typedef struct packed {
    logic ins;  // accepted insert into a queue with room
    logic rem;  // accepted remove from a queue that is not empty
  } bpq_ctrl_t;

endpackage

### src/bpq_cell.sv
`timescale 1ns / 1ps

module bpq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpq_pkg::bpq_ctrl_t  ctrl_i,
  input  bpq_pkg::bpq_entry_t new_i,
  input  bpq_pkg::bpq_entry_t left_i,
  input  logic                left_ge_i,
  input  logic                left_occ_i,
  input  bpq_pkg::bpq_entry_t right_i,
  input  logic                right_occ_i,
  output bpq_pkg::bpq_entry_t entry_o,
  output logic                ge_o,
  output logic                occ_o
);
  import bpq_pkg::*;

  bpq_entry_t entry_q, entry_d;
  logic       occ_q, occ_d;

  // This cell stays put on insert when it holds an entry at least as urgent as the new one.
  assign ge_o = occ_q && (entry_q.prio >= new_i.prio);

  // Next contents: keep, take the new item, or take a neighbour's entry.
  always_comb begin
    entry_d = entry_q;
    occ_d   = occ_q;
    if (ctrl_i.ins) begin
      occ_d = left_occ_i;
      if (!ge_o) begin
        if (left_ge_i) begin
          entry_d = new_i;
        end else begin
          entry_d = left_i;
        end
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
      occ_d   = right_occ_i;
    end
  end

  // Occupancy is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign occ_o   = occ_q;

endmodule

### src/bounded_priority_queue.sv
`timescale 1ns / 1ps

// Bounded priority queue built as a row of CAPACITY cells kept in leaving order,
// the head in the first cell. Every cell compares its priority with that of an
// incoming insert in parallel, so an insert opens a gap at its place and the
// tail shifts one cell along, while a remove shifts the whole row one cell
// toward the head. One item is taken every clock cycle while the output register
// is free or being taken, and its result appears in the output register on the
// next cycle. Equal priorities leave in arrival order. An insert into a full
// queue returns status full, a remove from an empty queue returns status empty,
// and every result carries the count held afterwards (its low four bits). The
// stores need no clearing after reset.
module bounded_priority_queue #(
  parameter int unsigned CAPACITY = bpq_pkg::BpqCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value [31:0], priority_req [47:32]
  input  logic        s_axis_tuser,   // cmd [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_value [31:0], out_priority [47:32],
                                      // count [51:48], zero [55:52]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);
  import bpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  bpq_entry_t new_entry;
  bpq_ctrl_t  ctrl;
  logic       in_accept;
  logic       full, empty;

  bpq_entry_t cell_entry [CAPACITY+1];
  logic       cell_ge    [CAPACITY+1];
  logic       cell_occ   [CAPACITY+1];
  bpq_entry_t lead_entry;

  logic [CntW-1:0]   count_q, count_d;
  logic [CntW+3:0]   count_ext;
  logic              out_valid_q;
  logic [55:0]       out_data_q, out_data_d;
  logic [StatW-1:0]  out_stat_q, out_stat_d;
  logic [StatW-1:0]  stat;
  bpq_entry_t        out_entry;

  // Input handshake: the output register frees up when its item is taken.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign new_entry.value = s_axis_tdata[31:0];
  assign new_entry.prio  = s_axis_tdata[47:32];

  assign full  = cell_occ[CAPACITY-1];
  assign empty = !cell_occ[0];

  assign ctrl.ins = in_accept && (s_axis_tuser == CmdInsert) && !full;
  assign ctrl.rem = in_accept && (s_axis_tuser == CmdRemove) && !empty;

  // The position before the head always counts as occupied and more urgent.
  assign lead_entry = new_entry;

  // Row of cells, each wired to both neighbours.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .left_i      ((g == 0) ? lead_entry : cell_entry[(g == 0) ? 0 : g-1]),
      .left_ge_i   ((g == 0) ? 1'b1 : cell_ge[(g == 0) ? 0 : g-1]),
      .left_occ_i  ((g == 0) ? 1'b1 : cell_occ[(g == 0) ? 0 : g-1]),
      .right_i     (cell_entry[g+1]),
      .right_occ_i (cell_occ[g+1]),
      .entry_o     (cell_entry[g]),
      .ge_o        (cell_ge[g]),
      .occ_o       (cell_occ[g])
    );
  end

  // Beyond the tail there is nothing to shift in.
  assign cell_entry[CAPACITY] = '0;
  assign cell_ge[CAPACITY]    = 1'b0;
  assign cell_occ[CAPACITY]   = 1'b0;

  // Entry count follows the accepted shifts.
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign count_ext = {4'b0000, count_d};

  // Result of the item accepted this cycle.
  always_comb begin
    stat      = StatOk;
    out_entry = '0;
    if (s_axis_tuser == CmdInsert) begin
      if (full) begin
        stat = StatFull;
      end
    end else if (empty) begin
      stat = StatEmpty;
    end else begin
      out_entry = cell_entry[0];
    end
    out_stat_d = stat;
    out_data_d = {4'b0000, count_ext[3:0], out_entry.prio, out_entry.value};
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

### dv/bounded_priority_queue_tb.sv
`timescale 1ns / 1ps

module bounded_priority_queue_tb;
  import bpq_pkg::*;

  localparam int unsigned Capacity   = BpqCapacity;
  localparam int unsigned RandItems  = 800;
  localparam int unsigned BurstLen   = 40;
  localparam int unsigned HoldCycles = 120;
  localparam int unsigned HoldAfter  = 60;
  localparam int unsigned CycLimit   = 20000;
  localparam int unsigned GapPct     = 7;

  // One command waiting to be sent.
  typedef struct {
    logic                     cmd;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } pq_cmd_t;

  // One reply as the queue should give it.
  typedef struct {
    logic [StatW-1:0]         status;
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
    logic [CountW-1:0]        count;
  } pq_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // value [31:0], priority_req [47:32]
  logic        s_axis_tuser = CmdInsert;   // cmd [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // out_value [31:0], out_priority [47:32],
                                    // count [51:48], zero [55:52]
  logic [1:0]  m_axis_tuser;        // status [1:0]

  // Commands still to be sent, and the replies they are owed.
  pq_cmd_t   cmd_q[$];
  pq_reply_t reply_q[$];

  // Shadow copy of the sorted store, head at index zero.
  logic signed [ValueW-1:0] shadow_val[Capacity];
  logic signed [PrioW-1:0]  shadow_pri[Capacity];
  int unsigned              shadow_cnt = 0;

  int unsigned cyc = 0;
  int unsigned err_cnt = 0;
  int unsigned n_sent = 0;
  int unsigned n_ins = 0;
  int unsigned n_full = 0;
  int unsigned n_rem = 0;
  int unsigned n_empty = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          in_taken = 1'b0;
  pq_cmd_t     next_cmd;

  bounded_priority_queue i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock with a period of 8 ns.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one command to the shadow store and return the reply it earns.
  function automatic pq_reply_t sorted_queue_apply(input pq_cmd_t c);
    pq_reply_t   r;
    int unsigned pos;
    int unsigned i;
    r.status = StatOk;
    r.value  = '0;
    r.prio   = '0;
    if (c.cmd == CmdInsert) begin
      if (shadow_cnt >= Capacity) begin
        r.status = StatFull;
        n_full++;
      end else begin
        // New entry goes behind every entry of equal or higher priority.
        pos = 0;
        while (pos < shadow_cnt && shadow_pri[pos] >= c.prio) pos++;
        for (i = shadow_cnt; i > pos; i--) begin
          shadow_val[i] = shadow_val[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_val[pos] = c.value;
        shadow_pri[pos] = c.prio;
        shadow_cnt++;
        n_ins++;
      end
    end else begin
      if (shadow_cnt == 0) begin
        r.status = StatEmpty;
        n_empty++;
      end else begin
        r.value = shadow_val[0];
        r.prio  = shadow_pri[0];
        for (i = 1; i < shadow_cnt; i++) begin
          shadow_val[i-1] = shadow_val[i];
          shadow_pri[i-1] = shadow_pri[i];
        end
        shadow_cnt--;
        n_rem++;
      end
    end
    r.count = CountW'(shadow_cnt);
    return r;
  endfunction

  // Random gap roll, suppressed inside the quiet window.
  function automatic bit gap_roll();
    if (cyc >= 300 && cyc < 500) begin
      return 1'b0;
    end
    return $urandom_range(99) < GapPct;
  endfunction

  function automatic void add_cmd(input logic cmd, input logic signed [ValueW-1:0] v,
                                  input logic signed [PrioW-1:0] p);
    pq_cmd_t c;
    c.cmd   = cmd;
    c.value = v;
    c.prio  = p;
    cmd_q.push_back(c);
  endfunction

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: a valid item is held until it has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (cmd_q.size() != 0 && !gap_roll()) begin
        next_cmd = cmd_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {next_cmd.prio, next_cmd.value};
        s_axis_tuser  <= next_cmd.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off so the input backs up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && n_sent >= HoldAfter) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles - 1;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= !gap_roll();
    end
  end

  // Monitor: check replies first, then predict for the item taken now.
  always @(posedge clk_i) begin
    pq_reply_t exp_r;
    pq_cmd_t   c;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          $error("reply with no command outstanding: status %0d", m_axis_tuser);
          err_cnt++;
        end else begin
          exp_r = reply_q.pop_front();
          if (m_axis_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
            err_cnt++;
          end
          if (m_axis_tdata[31:0] !== exp_r.value) begin
            $error("out_value: expected %0d, got %0d", exp_r.value,
                   $signed(m_axis_tdata[31:0]));
            err_cnt++;
          end
          if (m_axis_tdata[47:32] !== exp_r.prio) begin
            $error("out_priority: expected %0d, got %0d", exp_r.prio,
                   $signed(m_axis_tdata[47:32]));
            err_cnt++;
          end
          if (m_axis_tdata[51:48] !== exp_r.count) begin
            $error("count: expected %0d, got %0d", exp_r.count, m_axis_tdata[51:48]);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        c.cmd   = s_axis_tuser;
        c.value = s_axis_tdata[31:0];
        c.prio  = s_axis_tdata[47:32];
        reply_q.push_back(sorted_queue_apply(c));
        n_sent++;
      end
    end
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  // Stimulus, reset and end of run.
  initial begin
    pq_cmd_t     c;
    int unsigned ins_pct;
    int unsigned b;
    int unsigned k;

    // Directed: empty remove, extremes, ties, a full refusal, then drain.
    add_cmd(CmdRemove, 32'sh1234_5678, 16'sh7fff);
    add_cmd(CmdInsert, 32'sh7fff_ffff, 16'sh7fff);
    add_cmd(CmdInsert, 32'sh8000_0000, 16'sh8000);
    add_cmd(CmdInsert, 32'sd0, 16'sd0);
    add_cmd(CmdInsert, -32'sd1, -16'sd1);
    add_cmd(CmdInsert, 32'sd11, 16'sd5);
    add_cmd(CmdInsert, 32'sd22, 16'sd5);
    add_cmd(CmdInsert, 32'sd33, 16'sd5);
    add_cmd(CmdInsert, 32'sd44, 16'sh7fff);
    add_cmd(CmdInsert, 32'sd55, 16'sd5);
    for (k = 0; k < Capacity + 1; k++) begin
      add_cmd(CmdRemove, $urandom(), PrioW'($urandom()));
    end

    // Random bursts leaning towards filling, balancing or draining the queue.
    for (b = 0; b < RandItems / BurstLen; b++) begin
      case ($urandom_range(2))
        0: ins_pct = 80;
        1: ins_pct = 50;
        default: ins_pct = 20;
      endcase
      for (k = 0; k < BurstLen; k++) begin
        c.cmd   = ($urandom_range(99) < ins_pct) ? CmdInsert : CmdRemove;
        c.value = $urandom();
        // Mostly a narrow band of priorities so that ties are common.
        if ($urandom_range(3) == 0) begin
          c.prio = PrioW'($urandom());
        end else begin
          c.prio = PrioW'(int'($urandom_range(8)) - 4);
        end
        cmd_q.push_back(c);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d inserts, %0d refused on a full queue, %0d removes and %0d",
             n_ins, n_full, n_rem, n_empty);
    $display("removes on an empty queue, with a %0d-cycle receiver hold-off and random gaps.",
             HoldCycles);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
src/bpq_pkg.sv
src/bpq_cell.sv
src/bounded_priority_queue.sv
dv/bounded_priority_queue_tb.sv
